// File: design/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/fpm_pkg.sv
package fpm_pkg;
	localparam logic [1:0] RM_RTZ = 2'd0;
	localparam logic [1:0] RM_RNE = 2'd1;
	localparam logic [1:0] RM_RUP = 2'd2;
	localparam logic [1:0] RM_RDN = 2'd3;
	localparam logic [2:0] CLS_NORMAL = 3'd0;
	localparam logic [2:0] CLS_SUBNORMAL = 3'd1;
	localparam logic [2:0] CLS_ZERO = 3'd2;
	localparam logic [2:0] CLS_INF = 3'd3;
	localparam logic [2:0] CLS_NAN = 3'd4;
	localparam logic [31:0] QNAN_ZERO_INF = 32'hFFC00000;
	localparam logic [31:0] MAX_FINITE = 32'h7F7FFFFF;
	localparam logic [31:0] INF_BITS = 32'h7F800000;
	localparam logic signed [10:0] EXP_BIAS = 11'sd127;
	localparam logic signed [10:0] EXP_MIN = -11'sd126;

	typedef struct packed {
		logic        special;
		logic [31:0] special_val;
		logic        sign;
		logic [1:0]  mode;
	} ctl_t;

	function automatic logic [4:0] lz23(input logic [22:0] m);
		logic [4:0] n;
		n = 5'd23;
		for (int i = 0; i < 23; i++) begin
			if (m[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	function automatic logic [2:0] classify(input logic [31:0] b);
		logic [2:0] c;
		if (b[30:23] == 8'h00) c = (b[22:0] == 23'd0) ? CLS_ZERO : CLS_SUBNORMAL;
		else if (b[30:23] == 8'hFF) c = (b[22:0] == 23'd0) ? CLS_INF : CLS_NAN;
		else c = CLS_NORMAL;
		return c;
	endfunction
endpackage

// File: design/fp32_multiplier_rounding_core.sv
// channel | direction | payload
// s_axis  | in        | tdata = left_operand, right_operand
// m_axis  | out       | tdata = product, result_class
// cfg     | in        | cfg_data = rounding_mode
// Four register stages: unpack, multiply, round, output; one beat per cycle unless m_axis stalls.
// An accepted beat passes through the unpack, multiply, round and output registers in turn.
// Reset clears valid bits and sets rounding mode to nearest even.
// A stall on m_axis holds every stage; no beat is lost or repeated.
module fp32_multiplier_rounding_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // left_operand, right_operand
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // product, result_class, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);
	import fpm_pkg::*;
	`include "assert_macros.svh"
	logic [1:0] mode_q;
	logic v_s1, v_s2, v_s3, v_s4, en;
	ctl_t ctl_s1, ctl_s2;
	logic [23:0] sa_s1, sb_s1;
	logic signed [10:0] e_s1, e_s2;
	logic [47:0] p_s2;
	logic [31:0] res, res_s3;
	logic [31:0] prod_s4;
	logic [2:0] cls_s4;

	assign en = !v_s4 || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata = {5'd0, cls_s4, prod_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RM_RNE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (cfg_valid) mode_q <= cfg_data;
			if (en) begin
				v_s1 <= s_axis_tvalid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	fpm_unpack u_unpack (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(s_axis_tdata[31:0]), .b(s_axis_tdata[63:32]), .mode(mode_q),
		.ctl_s1(ctl_s1), .sa_s1(sa_s1), .sb_s1(sb_s1), .e_s1(e_s1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			e_s2 <= e_s1;
			p_s2 <= sa_s1 * sb_s1;
			res_s3 <= res;
			prod_s4 <= res_s3;
			cls_s4 <= classify(res_s3);
		end
	end

	fpm_round u_round (.ctl(ctl_s2), .p_in(p_s2), .e_in(e_s2), .res(res));

	`ASSERT_NEXT(a_hold, clk, arst_n, v_s4 && !m_axis_tready, v_s4 && $stable(m_axis_tdata))
	`ASSERT_IMPL(a_ready, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`ASSERT_NEXT(a_adv, clk, arst_n, en && v_s3, v_s4)
endmodule

// File: design/fpm_unpack.sv
module fpm_unpack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	input  logic [1:0]          mode,
	output fpm_pkg::ctl_t       ctl_s1,
	output logic [23:0]         sa_s1,
	output logic [23:0]         sb_s1,
	output logic signed [10:0]  e_s1
);
	import fpm_pkg::*;
	logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [4:0] la, lb;
	logic [23:0] sa, sb;
	logic signed [10:0] xa, xb;
	ctl_t ctl;

	assign nan_a = a[30:23] == 8'hFF && a[22:0] != 23'd0;
	assign nan_b = b[30:23] == 8'hFF && b[22:0] != 23'd0;
	assign inf_a = a[30:23] == 8'hFF && a[22:0] == 23'd0;
	assign inf_b = b[30:23] == 8'hFF && b[22:0] == 23'd0;
	assign zero_a = a[30:0] == 31'd0;
	assign zero_b = b[30:0] == 31'd0;
	assign la = lz23(a[22:0]);
	assign lb = lz23(b[22:0]);

	always_comb begin
		if (a[30:23] == 8'h00) begin
			sa = {1'b0, a[22:0]} << la;
			xa = EXP_MIN - 11'(signed'({6'd0, la}));
		end else begin
			sa = {1'b1, a[22:0]};
			xa = 11'(signed'({3'd0, a[30:23]})) - EXP_BIAS;
		end
		if (b[30:23] == 8'h00) begin
			sb = {1'b0, b[22:0]} << lb;
			xb = EXP_MIN - 11'(signed'({6'd0, lb}));
		end else begin
			sb = {1'b1, b[22:0]};
			xb = 11'(signed'({3'd0, b[30:23]})) - EXP_BIAS;
		end
		ctl.sign = a[31] ^ b[31];
		ctl.mode = mode;
		ctl.special = 1'b1;
		if (nan_a) ctl.special_val = a;
		else if (nan_b) ctl.special_val = b;
		else if ((zero_a && inf_b) || (inf_a && zero_b)) ctl.special_val = QNAN_ZERO_INF;
		else if (zero_a || zero_b) ctl.special_val = {ctl.sign, 31'd0};
		else if (inf_a || inf_b) ctl.special_val = {ctl.sign, INF_BITS[30:0]};
		else begin
			ctl.special = 1'b0;
			ctl.special_val = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			sa_s1 <= '0;
			sb_s1 <= '0;
			e_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
			sa_s1 <= sa;
			sb_s1 <= sb;
			e_s1 <= xa + xb;
		end
	end
endmodule

// File: design/fpm_round.sv
module fpm_round (
	input  fpm_pkg::ctl_t       ctl,
	input  logic [47:0]         p_in,
	input  logic signed [10:0]  e_in,
	output logic [31:0]         res
);
	import fpm_pkg::*;
	logic [47:0] p;
	logic signed [10:0] e, e2, extra;
	logic [5:0] shift;
	logic [48:0] pw;
	logic [24:0] kept;
	logic rnd, sticky, inc, neg, to_inf;
	logic [48:0] mask;

	always_comb begin
		neg = ctl.sign;
		to_inf = ctl.mode == RM_RNE || (ctl.mode == RM_RUP && !neg) ||
			(ctl.mode == RM_RDN && neg);
		if (p_in[47]) begin
			p = p_in;
			e = e_in + 11'sd1;
		end else begin
			p = {p_in[46:0], 1'b0};
			e = e_in;
		end
		extra = EXP_MIN - e;
		if (e >= EXP_MIN) shift = 6'd24;
		else if (extra > 11'sd25) shift = 6'd49;
		else shift = 6'd24 + 6'(extra);
		pw = {1'b0, p};
		kept = 25'(pw >> shift);
		rnd = pw[shift - 6'd1];
		mask = (49'd1 << (shift - 6'd1)) - 49'd1;
		sticky = (pw & mask) != 49'd0;
		case (ctl.mode)
			RM_RNE: inc = rnd && (sticky || kept[0]);
			RM_RUP: inc = (rnd || sticky) && !neg;
			RM_RDN: inc = (rnd || sticky) && neg;
			default: inc = 1'b0;
		endcase
		kept = kept + {24'd0, inc};
		e2 = e;
		if (ctl.special) res = ctl.special_val;
		else if (e > EXP_BIAS) res = to_inf ? {neg, INF_BITS[30:0]} : {neg, MAX_FINITE[30:0]};
		else if (e >= EXP_MIN) begin
			if (kept[24]) begin
				kept = {1'b0, kept[24:1]};
				e2 = e + 11'sd1;
			end
			if (e2 > EXP_BIAS)
				res = to_inf ? {neg, INF_BITS[30:0]} : {neg, MAX_FINITE[30:0]};
			else
				res = {neg, 8'(e2 + EXP_BIAS), kept[22:0]};
		end else res = {neg, 7'd0, kept[23:0]};
	end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import fpm_pkg::*;

	typedef struct packed {
		logic [31:0] right_operand;
		logic [31:0] left_operand;
	} operand_pair_t;

	typedef struct packed {
		logic [31:0] product;
		logic [2:0]  result_class;
	} product_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;

	fp32_multiplier_rounding_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	localparam int WATCHDOG_LIMIT = 20000;

	operand_pair_t pending_pairs[$];
	product_t      expected_products[$];
	logic [1:0]    model_mode;
	int            error_count;
	int            idle_cycles;
	bit            quiet_phase;
	bit            hold_sink;
	int            hold_sink_left;
	int            src_gap;
	int            sink_gap;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [31:0] fp_multiply(input logic [31:0] a, input logic [31:0] b,
			input logic [1:0] mode);
		logic        neg;
		logic        to_inf;
		logic [63:0] sa, sb, p, kept;
		int          xa, xb, e, shift;
		logic        rnd, sticky, inc;
		logic [31:0] sgn;
		sgn = (a ^ b) & 32'h80000000;
		neg = sgn[31];
		to_inf = (mode == RM_RNE) || (mode == RM_RUP && !neg) || (mode == RM_RDN && neg);
		if (a[30:23] == 8'hFF && a[22:0] != 0) return a;
		if (b[30:23] == 8'hFF && b[22:0] != 0) return b;
		if ((a[30:0] == 0 && b[30:0] == INF_BITS) || (a[30:0] == INF_BITS && b[30:0] == 0))
			return QNAN_ZERO_INF;
		if (a[30:0] == 0 || b[30:0] == 0) return sgn;
		if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return sgn | INF_BITS;
		sa = {41'd0, a[22:0]};
		xa = -126;
		if (a[30:23] == 0) begin
			while (!sa[23]) begin
				sa = sa << 1;
				xa--;
			end
		end else begin
			sa[23] = 1'b1;
			xa = int'(a[30:23]) - 127;
		end
		sb = {41'd0, b[22:0]};
		xb = -126;
		if (b[30:23] == 0) begin
			while (!sb[23]) begin
				sb = sb << 1;
				xb--;
			end
		end else begin
			sb[23] = 1'b1;
			xb = int'(b[30:23]) - 127;
		end
		p = sa * sb;
		e = xa + xb;
		if (p[47]) e++;
		else p = p << 1;
		if (e > 127) return to_inf ? (sgn | INF_BITS) : (sgn | MAX_FINITE);
		if (e >= -126) shift = 24;
		else shift = (-126 - e > 25) ? 49 : 24 + (-126 - e);
		kept = p >> shift;
		rnd = p[shift - 1];
		sticky = (p & ((64'd1 << (shift - 1)) - 1)) != 0;
		case (mode)
			RM_RNE: inc = rnd && (sticky || kept[0]);
			RM_RUP: inc = (rnd || sticky) && !neg;
			RM_RDN: inc = (rnd || sticky) && neg;
			default: inc = 1'b0;
		endcase
		if (inc) kept++;
		if (e >= -126) begin
			if (kept == (64'd1 << 24)) begin
				kept = kept >> 1;
				e++;
			end
			if (e > 127) return to_inf ? (sgn | INF_BITS) : (sgn | MAX_FINITE);
			return sgn | (32'(e + 127) << 23) | {9'd0, kept[22:0]};
		end
		return sgn | {8'd0, kept[23:0]};
	endfunction

	function automatic logic [2:0] class_of(input logic [31:0] r);
		if (r[30:23] == 8'h00) return (r[22:0] == 0) ? CLS_ZERO : CLS_SUBNORMAL;
		if (r[30:23] == 8'hFF) return (r[22:0] == 0) ? CLS_INF : CLS_NAN;
		return CLS_NORMAL;
	endfunction

	function automatic logic [31:0] random_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'h00;
			1: v[30:23] = 8'hFF;
			2: v[30:23] = 8'(
				$urandom_range(1, 40));
			3: v[30:23] = 8'($urandom_range(215, 254));
			4: v[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
			5: v[30:0] = 31'($urandom_range(0, 3));
			default: v[30:23] = 8'($urandom_range(64, 190));
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic add_pair(input logic [31:0] a, input logic [31:0] b);
		pending_pairs.push_back('{b, a});
	endtask

	task automatic write_mode(input logic [1:0] m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		model_mode = m;
	endtask

	task automatic drain();
		while (pending_pairs.size() != 0 || expected_products.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (src_gap > 0) begin
			src_gap <= src_gap - 1;
			if (s_axis_tvalid && s_axis_tready) s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				void'(pending_pairs.pop_front());
				expected_products.push_back('{fp_multiply(s_axis_tdata[31:0],
					s_axis_tdata[63:32], model_mode), 3'd0});
			end
			if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				src_gap <= $urandom_range(0, 7);
				s_axis_tvalid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_pairs[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_products.size() == 0) begin
				report_mismatch("unexpected product", m_axis_tdata[31:0], 32'h0);
			end else begin
				if (m_axis_tdata[31:0] !== expected_products[0].product)
					report_mismatch("product", m_axis_tdata[31:0],
						expected_products[0].product);
				if (m_axis_tdata[34:32] !== class_of(expected_products[0].product))
					report_mismatch("result_class", 32'(m_axis_tdata[34:32]),
						32'(class_of(expected_products[0].product)));
				void'(expected_products.pop_front());
			end
		end
		if (hold_sink_left > 0) begin
			hold_sink_left <= hold_sink_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_sink) begin
			hold_sink_left <= 300;
			hold_sink <= 1'b0;
			m_axis_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
			sink_gap <= $urandom_range(0, 7);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fp32_multiplier_rounding_core: mismatch");
			$finish;
		end
	end

	initial begin
		logic [31:0] edge_vals[12];
		int phase;
		edge_vals = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
			32'h7FC00001, 32'hFF812345, 32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF,
			32'h00800000, 32'h3F800000, 32'hBFFFFFFF};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = RM_RNE;
		model_mode = RM_RNE;
		error_count = 0;
		idle_cycles = 0;
		quiet_phase = 1'b0;
		hold_sink = 1'b0;
		hold_sink_left = 0;
		src_gap = 0;
		sink_gap = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_pair(32'h7FC00001, 32'h7F800001);
		add_pair(32'h3F800000, 32'hFFBFFFFF);
		add_pair(32'h00000000, 32'hFF800000);
		add_pair(32'h7F800000, 32'h80000000);
		add_pair(32'h80000000, 32'h3F800000);
		add_pair(32'hFF800000, 32'h3F800000);
		add_pair(32'h7F7FFFFF, 32'h7F7FFFFF);
		add_pair(32'hFF7FFFFF, 32'h40000000);
		add_pair(32'h00000001, 32'h00000001);
		add_pair(32'h80000001, 32'h3F000000);
		add_pair(32'h00800000, 32'h3F7FFFFF);
		add_pair(32'h007FFFFF, 32'h3F800001);
		add_pair(32'h3FFFFFFF, 32'h3FFFFFFF);
		add_pair(32'h3F800001, 32'hBF800001);
		add_pair(32'hFFFFFFFF, 32'h00000000);
		add_pair(32'h00400000, 32'h40000000);
		drain();
		for (phase = 0; phase < 8; phase++) begin
			write_mode(2'(phase));
			if (phase == 2) hold_sink = 1'b1;
			if (phase == 7) quiet_phase = 1'b1;
			for (int i = 0; i < 12; i++)
				for (int j = 0; j < 12; j += 4)
					add_pair(edge_vals[i], edge_vals[(i + j + phase) % 12]);
			for (int i = 0; i < 150; i++)
				add_pair(random_operand(), random_operand());
			drain();
		end
		if (error_count == 0)
			$display("fp32_multiplier_rounding_core: match");
		else
			$display("fp32_multiplier_rounding_core: mismatch");
		$finish;
	end
endmodule
